// File: rtl/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg: shared types and constants of the linear-probing hash table
// Holds the request and response beat types and the codes carried in them.
// ----------------------------------------------------------------------------
package lpht_pkg;

  localparam int unsigned KEY_W     = 64;
  localparam int unsigned PAYLOAD_W = 32;
  localparam int unsigned PROBE_W   = 6;
  localparam int unsigned CFG_W     = 7;

  typedef enum logic {
    REQ_INSERT = 1'b0,
    REQ_SEARCH = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_INSERTED  = 2'd0,
    ST_FULL      = 2'd1,
    ST_FOUND     = 2'd2,
    ST_NOT_FOUND = 2'd3
  } status_e;

  typedef struct packed {
    req_e                 req_type;
    logic [KEY_W-1:0]     key;
    logic [PAYLOAD_W-1:0] payload;
  } req_t;

  typedef struct packed {
    status_e              status;
    logic [PAYLOAD_W-1:0] payload_out;
    logic [PROBE_W-1:0]   probe_count;
  } rsp_t;

endpackage

// File: rtl/linear_probe_hash_table_core.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core: open-addressed hash table with linear probing
// Insert and search of byte-string keys, one request at a time.
// ----------------------------------------------------------------------------
// Usage notes.
// A request beat (insert or search) enters on the in_* valid/ready channel and
// exactly one response beat leaves on the out_* channel. The key is cut at its
// first zero byte, its bytes are summed, and the home slot is that sum modulo
// the table size in use. The modulo runs on a shift-subtract remainder unit,
// one sum bit per cycle (11 sum bits for 8-byte keys). Probing then reads one
// slot per cycle from the slot RAMs; a read and its compare overlap. The block
// takes one request at a time: in_ready_o is high only while idle. A finished
// response sits in an output register; the next request is taken while it
// waits, but that request's response is held until the receiver has taken the
// earlier one, so a stalled receiver just holds the block. After reset the
// occupied map is swept to zero, one slot per cycle, and no request is taken
// during the sweep. The table size register resets to TABLE_DEPTH and may be
// written only while idle.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core #(
  parameter int unsigned TABLE_DEPTH = 64,
  parameter int unsigned KEY_BYTES   = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  lpht_pkg::req_t                  in_req_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output lpht_pkg::rsp_t                  out_rsp_o,
  input  logic                            cfg_we_i,
  input  logic [lpht_pkg::CFG_W-1:0]      cfg_wdata_i
);

  // Slot index, size and count widths.
  localparam int unsigned AW    = $clog2(TABLE_DEPTH);
  localparam int unsigned SW    = $clog2(TABLE_DEPTH + 1);
  // Stored key width and byte-sum width.
  localparam int unsigned KW    = 8 * KEY_BYTES;
  localparam int unsigned SUM_W = $clog2(KEY_BYTES * 255 + 1);
  localparam int unsigned BW    = $clog2(SUM_W);
  localparam int unsigned PW    = lpht_pkg::PAYLOAD_W;
  localparam int unsigned QW    = lpht_pkg::PROBE_W;
  // A data word holds the key, the payload and the recorded probe count.
  localparam int unsigned DW    = KW + PW + QW;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_DIV,
    S_PROBE,
    S_RESULT
  } state_e;

  // Control state.
  state_e         state_q, state_d;
  logic [SW-1:0]  size_q, size_d;
  logic [SW-1:0]  entry_q, entry_d;
  logic [AW-1:0]  clr_q, clr_d;
  logic [BW-1:0]  bit_q, bit_d;
  logic [SW-1:0]  iss_n_q, iss_n_d;
  logic           rd_vld_q, rd_vld_d;
  logic           out_valid_q, out_valid_d;

  // Request payload and datapath registers.
  lpht_pkg::req_e  req_q, req_d;
  logic [KW-1:0]   key_q, key_d;
  logic [PW-1:0]   pay_q, pay_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [SW-1:0]   rem_q, rem_d;
  logic [AW-1:0]   iss_slot_q, iss_slot_d;
  logic [AW-1:0]   rd_slot_q, rd_slot_d;
  logic [SW-1:0]   rd_n_q, rd_n_d;
  lpht_pkg::rsp_t  rsp_q, rsp_d;
  lpht_pkg::rsp_t  out_rsp_q, out_rsp_d;

  // Key cleaning and byte sum.
  logic [KW-1:0]    key_clean;
  logic [SUM_W-1:0] key_sum;

  // Remainder step.
  logic [SW:0]   rem_shift;
  logic [SW:0]   rem_sub;
  logic [SW-1:0] rem_next;

  // Probe datapath.
  logic [AW-1:0] iss_slot_inc;
  logic          rd_last;
  logic          hit;

  // RAM ports.
  logic          occ_we;
  logic [AW-1:0] occ_waddr;
  logic          occ_wdata;
  logic          occ_rdata;
  logic          dat_we;
  logic [DW-1:0] dat_wdata;
  logic [DW-1:0] dat_rdata;
  logic [KW-1:0] key_rd;
  logic [PW-1:0] pay_rd;
  logic [QW-1:0] probe_rd;

  // Occupied map: one bit per slot, swept to zero after reset.
  lpht_ram #(
    .WIDTH (1),
    .DEPTH (TABLE_DEPTH)
  ) u_occ_ram (
    .clk_i   (clk_i),
    .we_i    (occ_we),
    .waddr_i (occ_waddr),
    .wdata_i (occ_wdata),
    .raddr_i (iss_slot_q),
    .rdata_o (occ_rdata)
  );

  // Key, payload and probe count per slot; used only where occupied.
  lpht_ram #(
    .WIDTH (DW),
    .DEPTH (TABLE_DEPTH)
  ) u_dat_ram (
    .clk_i   (clk_i),
    .we_i    (dat_we),
    .waddr_i (rd_slot_q),
    .wdata_i (dat_wdata),
    .raddr_i (iss_slot_q),
    .rdata_o (dat_rdata)
  );

  assign key_rd   = dat_rdata[DW-1 -: KW];
  assign pay_rd   = dat_rdata[QW +: PW];
  assign probe_rd = dat_rdata[QW-1:0];

  // The key ends at its first zero byte; later bytes are cleared so that
  // the stored and compared key is the same whatever followed the end.
  always_comb begin
    logic       alive;
    logic [7:0] kbyte;
    alive     = 1'b1;
    key_clean = '0;
    key_sum   = '0;
    for (int b = 0; b < int'(KEY_BYTES); b++) begin
      kbyte = in_req_i.key[8*b +: 8];
      if (kbyte == 8'd0) begin
        alive = 1'b0;
      end
      if (alive) begin
        key_clean[8*b +: 8] = kbyte;
        key_sum             = key_sum + SUM_W'(kbyte);
      end
    end
  end

  // One restoring-remainder step: bring in the next sum bit, subtract the
  // table size when the partial remainder reaches it.
  assign rem_shift = {rem_q, sum_q[SUM_W-1]};
  assign rem_sub   = rem_shift - {1'b0, size_q};
  assign rem_next  = (rem_shift >= {1'b0, size_q}) ? SW'(rem_sub) : SW'(rem_shift);

  // Probing wraps within the slots in use.
  assign iss_slot_inc = (SW'(iss_slot_q) + SW'(1) == size_q) ? '0 : iss_slot_q + AW'(1);
  assign rd_last      = (SW'(rd_n_q + SW'(1)) == size_q);
  assign hit          = (req_q == lpht_pkg::REQ_INSERT) ? !occ_rdata
                                                        : (occ_rdata && (key_rd == key_q));

  assign dat_wdata = {key_q, pay_q, QW'(rd_n_q)};

  always_comb begin
    state_d     = state_q;
    size_d      = size_q;
    entry_d     = entry_q;
    clr_d       = clr_q;
    bit_d       = bit_q;
    iss_n_d     = iss_n_q;
    rd_vld_d    = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    req_d       = req_q;
    key_d       = key_q;
    pay_d       = pay_q;
    sum_d       = sum_q;
    rem_d       = rem_q;
    iss_slot_d  = iss_slot_q;
    rd_slot_d   = rd_slot_q;
    rd_n_d      = rd_n_q;
    rsp_d       = rsp_q;
    out_rsp_d   = out_rsp_q;
    occ_we      = 1'b0;
    occ_waddr   = rd_slot_q;
    occ_wdata   = 1'b1;
    dat_we      = 1'b0;

    // Out-of-range sizes are clamped when written.
    if (cfg_we_i) begin
      if (cfg_wdata_i == '0) begin
        size_d = SW'(1);
      end else if (32'(cfg_wdata_i) > TABLE_DEPTH) begin
        size_d = SW'(TABLE_DEPTH);
      end else begin
        size_d = SW'(cfg_wdata_i);
      end
    end

    case (state_q)
      S_CLEAR: begin
        occ_we    = 1'b1;
        occ_waddr = clr_q;
        occ_wdata = 1'b0;
        clr_d     = clr_q + AW'(1);
        if (clr_q == AW'(TABLE_DEPTH - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid_i) begin
          req_d   = in_req_i.req_type;
          key_d   = key_clean;
          pay_d   = in_req_i.payload;
          sum_d   = key_sum;
          rem_d   = '0;
          bit_d   = BW'(SUM_W - 1);
          state_d = S_DIV;
        end
      end
      S_DIV: begin
        rem_d = rem_next;
        sum_d = sum_q << 1;
        bit_d = bit_q - BW'(1);
        if (bit_q == '0) begin
          iss_slot_d = AW'(rem_next);
          iss_n_d    = '0;
          if ((req_q == lpht_pkg::REQ_INSERT) && (entry_q >= size_q)) begin
            rsp_d.status      = lpht_pkg::ST_FULL;
            rsp_d.payload_out = '0;
            rsp_d.probe_count = '0;
            state_d           = S_RESULT;
          end else begin
            state_d = S_PROBE;
          end
        end
      end
      S_PROBE: begin
        // Issue the next slot read while the previous one is compared.
        if (iss_n_q < size_q) begin
          rd_vld_d   = 1'b1;
          rd_slot_d  = iss_slot_q;
          rd_n_d     = iss_n_q;
          iss_slot_d = iss_slot_inc;
          iss_n_d    = iss_n_q + SW'(1);
        end
        if (rd_vld_q) begin
          if (hit) begin
            rd_vld_d = 1'b0;
            state_d  = S_RESULT;
            if (req_q == lpht_pkg::REQ_INSERT) begin
              occ_we            = 1'b1;
              dat_we            = 1'b1;
              entry_d           = entry_q + SW'(1);
              rsp_d.status      = lpht_pkg::ST_INSERTED;
              rsp_d.payload_out = '0;
              rsp_d.probe_count = QW'(rd_n_q);
            end else begin
              rsp_d.status      = lpht_pkg::ST_FOUND;
              rsp_d.payload_out = pay_rd;
              rsp_d.probe_count = probe_rd;
            end
          end else if (rd_last) begin
            rd_vld_d          = 1'b0;
            state_d           = S_RESULT;
            rsp_d.payload_out = '0;
            rsp_d.probe_count = '0;
            rsp_d.status      = (req_q == lpht_pkg::REQ_INSERT) ? lpht_pkg::ST_FULL
                                                                : lpht_pkg::ST_NOT_FOUND;
          end
        end
      end
      S_RESULT: begin
        // Hand over once the output register is free or being emptied.
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          out_rsp_d   = rsp_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      size_q      <= SW'(TABLE_DEPTH);
      entry_q     <= '0;
      clr_q       <= '0;
      bit_q       <= '0;
      iss_n_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      size_q      <= size_d;
      entry_q     <= entry_d;
      clr_q       <= clr_d;
      bit_q       <= bit_d;
      iss_n_q     <= iss_n_d;
      rd_vld_q    <= rd_vld_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    key_q      <= key_d;
    pay_q      <= pay_d;
    sum_q      <= sum_d;
    rem_q      <= rem_d;
    iss_slot_q <= iss_slot_d;
    rd_slot_q  <= rd_slot_d;
    rd_n_q     <= rd_n_d;
    rsp_q      <= rsp_d;
    out_rsp_q  <= out_rsp_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

endmodule

// File: rtl/lpht_ram.sv
// ----------------------------------------------------------------------------
// lpht_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; contents are not reset.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: test/linear_probe_hash_table_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// linear_probe_hash_table_core_tb: self-checking bench for the hash table core
// The bench first walks a short stimulus table. That table covers the empty
// table, the extreme keys, key cut-off, collisions, duplicates, the full table
// and the out-of-range sizes. Random phases at several table sizes follow.
// Every response beat is checked against the table model or a typed-in value.
// ----------------------------------------------------------------------------
module linear_probe_hash_table_core_tb;

  localparam int unsigned TABLE_DEPTH    = 64;
  localparam int unsigned KEY_BYTES      = 8;
  // Cycles without any beat before the run is declared hung. The limit covers
  // the slowest correct item plus the longest sender gap and receiver stall,
  // and the clearing sweep after reset.
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_ITEMS   = 128;

  // One line of the directed stimulus table. It holds either a table size
  // write or a request. Where the response is obvious, it is typed in.
  typedef struct {
    bit                         is_cfg;
    logic [lpht_pkg::CFG_W-1:0] size;
    lpht_pkg::req_t             req;
    bit                         typed;
    lpht_pkg::rsp_t             rsp;
  } row_t;

  logic                       clk_i = 1'b0;
  logic                       rst_ni;
  logic                       in_valid_i;
  logic                       in_ready_o;
  lpht_pkg::req_t             in_req_i;
  logic                       out_valid_o;
  logic                       out_ready_i = 1'b0;
  lpht_pkg::rsp_t             out_rsp_o;
  logic                       cfg_we_i;
  logic [lpht_pkg::CFG_W-1:0] cfg_wdata_i;

  // Sideband that travels with the request payload. It marks the directed
  // rows whose response is typed in rather than predicted.
  logic                       typed_q;
  lpht_pkg::rsp_t             typed_rsp_q;

  // Shadow copy of the table contents and of the size register.
  bit                             slot_used   [TABLE_DEPTH];
  logic [lpht_pkg::KEY_W-1:0]     slot_key    [TABLE_DEPTH];
  logic [lpht_pkg::PAYLOAD_W-1:0] slot_pay    [TABLE_DEPTH];
  logic [lpht_pkg::PROBE_W-1:0]   slot_probes [TABLE_DEPTH];
  int unsigned                    entries  = 0;
  logic [lpht_pkg::CFG_W-1:0]     size_reg = TABLE_DEPTH[lpht_pkg::CFG_W-1:0];

  lpht_pkg::rsp_t             pending_rsp [$];
  logic [lpht_pkg::KEY_W-1:0] key_pool [$];
  row_t                       plan [$];
  int unsigned                errors = 0;
  int unsigned                quiet_cycles = 0;
  bit                         tx_gaps = 1'b1;
  logic                       rx_stalls;
  int unsigned                rx_hold = 0;

  // The random phases step through small, zero, oversize and full sizes.
  // The entry count only grows, so the early phases fill the table gradually.
  logic [lpht_pkg::CFG_W-1:0] phase_sizes [9] = '{7'd16, 7'd1, 7'd40, 7'd0, 7'd23,
                                                  7'd64, 7'd127, 7'd9, 7'd64};

  linear_probe_hash_table_core uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #6 clk_i = ~clk_i;

  // Runs one request against the shadow table and returns its response.
  // The key is cut at its first zero byte. The home slot is the byte sum
  // modulo the size in use. Probing wraps within the slots in use.
  function automatic lpht_pkg::rsp_t probe_table(lpht_pkg::req_t r);
    logic [lpht_pkg::KEY_W-1:0] k;
    int unsigned                sz, slot, sum, n, b;
    bit                         ended, done;
    lpht_pkg::rsp_t             rsp;
    if (size_reg == 0) begin
      sz = 1;
    end else if (size_reg > TABLE_DEPTH) begin
      sz = TABLE_DEPTH;
    end else begin
      sz = size_reg;
    end
    k     = '0;
    ended = 1'b0;
    sum   = 0;
    for (b = 0; b < KEY_BYTES; b++) begin
      if (r.key[8*b +: 8] == 8'h00) ended = 1'b1;
      if (!ended) begin
        k[8*b +: 8] = r.key[8*b +: 8];
        sum += r.key[8*b +: 8];
      end
    end
    slot = sum % sz;
    done = 1'b0;
    rsp.payload_out = '0;
    rsp.probe_count = '0;
    if (r.req_type == lpht_pkg::REQ_INSERT) begin
      // The count check also covers entries stranded above a shrunk size.
      rsp.status = lpht_pkg::ST_FULL;
      if (entries < sz) begin
        for (n = 0; n < sz; n++) begin
          if (!done) begin
            if (!slot_used[slot]) begin
              slot_used[slot]   = 1'b1;
              slot_key[slot]    = k;
              slot_pay[slot]    = r.payload;
              slot_probes[slot] = n[lpht_pkg::PROBE_W-1:0];
              entries++;
              rsp.status      = lpht_pkg::ST_INSERTED;
              rsp.probe_count = n[lpht_pkg::PROBE_W-1:0];
              done = 1'b1;
            end else begin
              slot = (slot + 1) % sz;
            end
          end
        end
      end
    end else begin
      rsp.status = lpht_pkg::ST_NOT_FOUND;
      for (n = 0; n < sz; n++) begin
        if (!done) begin
          if (slot_used[slot] && slot_key[slot] == k) begin
            rsp.status      = lpht_pkg::ST_FOUND;
            rsp.payload_out = slot_pay[slot];
            rsp.probe_count = slot_probes[slot];
            done = 1'b1;
          end else begin
            slot = (slot + 1) % sz;
          end
        end
      end
    end
    return rsp;
  endfunction

  function automatic row_t op_row(lpht_pkg::req_e op, logic [lpht_pkg::KEY_W-1:0] key,
                                  logic [lpht_pkg::PAYLOAD_W-1:0] pay);
    row_t row;
    row.is_cfg       = 1'b0;
    row.size         = '0;
    row.req.req_type = op;
    row.req.key      = key;
    row.req.payload  = pay;
    row.typed        = 1'b0;
    row.rsp          = '0;
    return row;
  endfunction

  function automatic row_t known_row(lpht_pkg::req_e op, logic [lpht_pkg::KEY_W-1:0] key,
                                     logic [lpht_pkg::PAYLOAD_W-1:0] pay,
                                     lpht_pkg::status_e st,
                                     logic [lpht_pkg::PAYLOAD_W-1:0] po,
                                     logic [lpht_pkg::PROBE_W-1:0] pc);
    row_t row;
    row = op_row(op, key, pay);
    row.typed           = 1'b1;
    row.rsp.status      = st;
    row.rsp.payload_out = po;
    row.rsp.probe_count = pc;
    return row;
  endfunction

  function automatic row_t size_row(logic [lpht_pkg::CFG_W-1:0] v);
    row_t row;
    row = op_row(lpht_pkg::REQ_SEARCH, '0, '0);
    row.is_cfg = 1'b1;
    row.size   = v;
    return row;
  endfunction

  // Presents one request beat after an optional gap and returns at the edge
  // that accepts it. Valid stays high when no gap follows, so back-to-back
  // beats never lower and raise valid in the same time step.
  task automatic send_req(input lpht_pkg::req_t r, input bit typed,
                          input lpht_pkg::rsp_t want);
    int unsigned gap;
    gap = 0;
    if (tx_gaps && $urandom_range(0, 2) == 0) begin
      gap = ($urandom_range(0, 15) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    end
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_req_i    <= r;
    typed_q     <= typed;
    typed_rsp_q <= want;
    in_valid_i  <= 1'b1;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Writes the size register once the block is idle and every response
  // has come back. The idle test runs on the falling edge so that it never
  // races the response checker.
  task automatic write_table_size(input logic [lpht_pkg::CFG_W-1:0] v);
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_rsp.size() != 0 || !in_ready_o) @(negedge clk_i);
    @(posedge clk_i);
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    size_reg = v;
  endtask

  // The receiver stalls at random: mostly short stalls, now and then a long
  // one. The stalls are switched off in some phases.
  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      rx_hold     <= rx_hold - 1;
      out_ready_i <= 1'b0;
    end else if (rx_stalls && $urandom_range(0, 3) == 0) begin
      rx_hold     <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40)
                                                  : $urandom_range(0, 3);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Scoreboard. An accepted request beat queues its expected response. A
  // typed-in response replaces the prediction, but the shadow table is
  // still updated. Each response beat is checked against the oldest entry.
  always @(posedge clk_i) begin : scoreboard
    lpht_pkg::rsp_t want;
    lpht_pkg::rsp_t predicted;
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        predicted = probe_table(in_req_i);
        pending_rsp.push_back(typed_q ? typed_rsp_q : predicted);
      end
      if (out_valid_o && out_ready_i) begin
        if (pending_rsp.size() == 0) begin
          $error("response beat with none pending: status %0d payload %h probes %0d",
                 out_rsp_o.status, out_rsp_o.payload_out, out_rsp_o.probe_count);
          errors++;
        end else begin
          want = pending_rsp.pop_front();
          if (out_rsp_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp_o.status);
            errors++;
          end
          if (out_rsp_o.payload_out !== want.payload_out) begin
            $error("payload_out: expected %h, got %h", want.payload_out,
                   out_rsp_o.payload_out);
            errors++;
          end
          if (out_rsp_o.probe_count !== want.probe_count) begin
            $error("probe_count: expected %0d, got %0d", want.probe_count,
                   out_rsp_o.probe_count);
            errors++;
          end
        end
      end
    end
  end

  // A hang shows up as a long run of cycles with no beat on either channel.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  initial begin
    lpht_pkg::req_t             r;
    logic [lpht_pkg::KEY_W-1:0] k;
    int unsigned                i, b, len;
    bit                         ended;

    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    in_req_i    = '0;
    typed_q     = 1'b0;
    typed_rsp_q = '0;
    cfg_we_i    = 1'b0;
    cfg_wdata_i = '0;
    rx_stalls   = 1'b1;

    // Directed table. At first the table is empty and runs at its reset
    // size of 64. The empty key lands in slot 0. The all-ones key sums to
    // 2040 and lands in slot 56.
    plan.push_back(known_row(lpht_pkg::REQ_SEARCH, 64'h0, 32'h0,
                             lpht_pkg::ST_NOT_FOUND, 32'h0, 6'd0));
    plan.push_back(known_row(lpht_pkg::REQ_INSERT, 64'h0, 32'h0,
                             lpht_pkg::ST_INSERTED, 32'h0, 6'd0));
    plan.push_back(known_row(lpht_pkg::REQ_SEARCH, 64'h0, 32'hFFFF_FFFF,
                             lpht_pkg::ST_FOUND, 32'h0, 6'd0));
    plan.push_back(known_row(lpht_pkg::REQ_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF,
                             lpht_pkg::ST_INSERTED, 32'h0, 6'd0));
    plan.push_back(known_row(lpht_pkg::REQ_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0,
                             lpht_pkg::ST_FOUND, 32'hFFFF_FFFF, 6'd0));
    // The bytes past a zero byte are not part of the key.
    plan.push_back(op_row(lpht_pkg::REQ_INSERT, 64'hAB00_0000_0000_0041, 32'h1234_5678));
    plan.push_back(op_row(lpht_pkg::REQ_SEARCH, 64'h0000_0000_0000_0041, 32'h0));
    plan.push_back(op_row(lpht_pkg::REQ_SEARCH, 64'h5A5A_0000_00C3_0041, 32'h0));
    // Collision chain from slot 0, then a duplicate key farther along it.
    plan.push_back(op_row(lpht_pkg::REQ_INSERT, 64'h40, 32'hA5A5_A5A5));
    plan.push_back(op_row(lpht_pkg::REQ_INSERT, 64'h40, 32'h5A5A_5A5A));
    plan.push_back(op_row(lpht_pkg::REQ_SEARCH, 64'h40, 32'hDEAD_BEEF));
    // A miss walks every slot in use.
    plan.push_back(op_row(lpht_pkg::REQ_SEARCH, 64'h0101, 32'h0));
    plan.push_back(op_row(lpht_pkg::REQ_INSERT, 64'h8080_8080_8080_8080, 32'h8000_0001));
    // Shrink to one slot. The count is already past the size, so an insert
    // reports a full table. Only slot 0 is still visited.
    plan.push_back(size_row(7'd1));
    plan.push_back(known_row(lpht_pkg::REQ_INSERT, 64'h77, 32'h1,
                             lpht_pkg::ST_FULL, 32'h0, 6'd0));
    plan.push_back(known_row(lpht_pkg::REQ_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0,
                             lpht_pkg::ST_NOT_FOUND, 32'h0, 6'd0));
    plan.push_back(op_row(lpht_pkg::REQ_SEARCH, 64'h0, 32'h0));
    // A size of zero behaves as a size of one.
    plan.push_back(size_row(7'd0));
    plan.push_back(known_row(lpht_pkg::REQ_INSERT, 64'h1, 32'h2,
                             lpht_pkg::ST_FULL, 32'h0, 6'd0));
    plan.push_back(op_row(lpht_pkg::REQ_SEARCH, 64'h0, 32'h0));
    // Oversize behaves as the full depth, so the stranded entries come back.
    plan.push_back(size_row(7'd127));
    plan.push_back(op_row(lpht_pkg::REQ_SEARCH, 64'hFFFF_FFFF_FFFF_FFFF, 32'h0));
    plan.push_back(op_row(lpht_pkg::REQ_SEARCH, 64'h8080_8080_8080_8080, 32'h0));
    plan.push_back(op_row(lpht_pkg::REQ_SEARCH, 64'h40, 32'h0));

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[n]) begin
      if (plan[n].is_cfg) begin
        write_table_size(plan[n].size);
      end else begin
        send_req(plan[n].req, plan[n].typed, plan[n].rsp);
      end
    end

    // Random phases. Most searches reuse inserted keys, with fresh bytes
    // past the terminator, so that they hit. Most inserts pile onto the
    // same keys and build collision chains.
    foreach (phase_sizes[p]) begin
      write_table_size(phase_sizes[p]);
      tx_gaps = (p % 3) != 1;
      rx_stalls <= (p % 3) != 2;
      for (i = 0; i < RANDOM_ITEMS; i++) begin
        r.payload  = $urandom;
        r.req_type = ($urandom_range(0, 9) < 4) ? lpht_pkg::REQ_INSERT
                                                : lpht_pkg::REQ_SEARCH;
        if (key_pool.size() != 0 && $urandom_range(0, 9) < 6) begin
          k = key_pool[$urandom_range(0, key_pool.size() - 1)];
          ended = 1'b0;
          for (b = 0; b < KEY_BYTES; b++) begin
            if (ended) begin
              k[8*b +: 8] = 8'($urandom_range(0, 255));
            end else if (k[8*b +: 8] == 8'h00) begin
              ended = 1'b1;
            end
          end
        end else if ($urandom_range(0, 7) == 0) begin
          k = {$urandom, $urandom};
        end else begin
          len = $urandom_range(0, KEY_BYTES);
          for (b = 0; b < KEY_BYTES; b++) begin
            if (b < len) begin
              k[8*b +: 8] = 8'($urandom_range(1, 255));
            end else if (b == len) begin
              k[8*b +: 8] = 8'h00;
            end else begin
              k[8*b +: 8] = 8'($urandom_range(0, 255));
            end
          end
        end
        r.key = k;
        if (r.req_type == lpht_pkg::REQ_INSERT) key_pool.push_back(k);
        send_req(r, 1'b0, '0);
      end
    end

    // Drain the responses still in flight, then wait out the worst-case
    // latency so that any stray beat shows up.
    in_valid_i <= 1'b0;
    @(negedge clk_i);
    while (pending_rsp.size() != 0) @(negedge clk_i);
    repeat (100) @(posedge clk_i);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
